// File: sv/ftsta_pkg.sv
// Shared constants, codes and control/status structs of the force/torque tare averager.
package ftsta_pkg;

	localparam int AXES              = 6;
	localparam int COUNT_WIDTH_DEF   = 10;
	localparam int VALUE_WIDTH_DEF   = 32;
	localparam int WEIGHT_WIDTH      = 31;
	localparam int FRAC_BITS         = 16;
	localparam int WINDOW_RESET      = 250;
	localparam int SCALE_ONE         = 65536;
	localparam int AXIS_W            = 3;
	localparam int IDX_W             = 4;

	// command codes
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_AIR    = 2'd1;
	localparam logic [1:0] CMD_GROUND = 2'd2;
	localparam logic [1:0] CMD_APPLY  = 2'd3;

	// window modes
	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_AIR    = 2'd1;
	localparam logic [1:0] MODE_GROUND = 2'd2;

	// result status codes
	localparam logic [2:0] ST_STARTED     = 3'd0;
	localparam logic [2:0] ST_BUSY        = 3'd1;
	localparam logic [2:0] ST_AIR_DONE    = 3'd2;
	localparam logic [2:0] ST_GROUND_DONE = 3'd3;
	localparam logic [2:0] ST_APPLIED     = 3'd4;
	localparam logic [2:0] ST_NO_DATA     = 3'd5;
	localparam logic [2:0] ST_ZERO_DIV    = 3'd6;

	// configuration register indexes
	localparam logic CFG_WINDOW = 1'b0;
	localparam logic CFG_WEIGHT = 1'b1;

	typedef struct packed {
		logic              ready;
		logic              acc;
		logic              bump;
		logic              clear;
		logic              den;
		logic              div_avg;
		logic              div_scale;
		logic              store_avg;
		logic              store_scale;
		logic              finish;
		logic              emit;
		logic [2:0]        code;
		logic              side;
		logic              with_avg;
		logic              last;
		logic [AXIS_W-1:0] axis;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       foot;
		logic [1:0] mode;
		logic       both_valid;
		logic       win_hit;
		logic       den_zero;
		logic       div_done;
		logic       out_free;
	} sts_t;

endpackage

// File: sv/ft_sensor_tare_averager_top.sv
// Top level of the two-foot force/torque tare averager.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------------
//  s_*     | in        | s_tvalid / s_tready      | tuser: command, foot; tdata: six raw values
//  m_*     | out       | m_tvalid / m_tready      | tuser: status, side; tdata: six averages,
//          |           |                          | scale; tlast: final result of an item
//  cfg_*   | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data (always ready)
//
// Flow: an item is taken only when the sequencer is idle. A command item
// waits for a free result register. The sample item that closes a window
// adds twelve divisions in the bit-serial shared divider, whose dividend is
// 48 bits wide at defaults. Apply adds one division.
// Reset is asynchronous; the result register frees itself as soon as m_tready
// takes its item, so an item may be taken while a result still waits.
module ft_sensor_tare_averager_top #(
	parameter int COUNT_WIDTH = ftsta_pkg::COUNT_WIDTH_DEF,
	parameter int VALUE_WIDTH = ftsta_pkg::VALUE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// [1:0] command, [2] foot
	input  logic [2:0] s_tuser,
	// force_x, force_y, force_z, torque_x, torque_y, torque_z, zero fill
	input  logic [((ftsta_pkg::AXES*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// [2:0] status, [3] side
	output logic [3:0] m_tuser,
	// avg_force_x .. avg_torque_z, scale_factor, zero fill
	output logic [(((ftsta_pkg::AXES+1)*VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic m_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [ftsta_pkg::WEIGHT_WIDTH-1:0] cfg_data
);
	import ftsta_pkg::*;

	localparam int OUT_W  = (AXES + 1) * VALUE_WIDTH;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	ctl_t             ctl;
	sts_t             sts;
	logic             in_fire;
	logic [2:0]       o_status;
	logic             o_side;
	logic [OUT_W-1:0] o_vals;

	assign s_tready  = ctl.ready;
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	ftsta_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.sts     (sts),
		.ctl     (ctl)
	);

	ftsta_dp #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.in_cmd     (s_tuser[1:0]),
		.in_foot    (s_tuser[2]),
		.in_vals    (s_tdata[AXES*VALUE_WIDTH-1:0]),
		.cfg_fire   (cfg_valid && cfg_ready),
		.cfg_idx    (cfg_index),
		.cfg_val    (cfg_data),
		.ctl        (ctl),
		.sts        (sts),
		.out_take   (m_tready),
		.out_valid  (m_tvalid),
		.out_status (o_status),
		.out_side   (o_side),
		.out_vals   (o_vals),
		.out_last   (m_tlast)
	);

	assign m_tuser = {o_side, o_status};
	assign m_tdata = OUT_TW'(o_vals);

endmodule

// File: sv/ftsta_ctrl.sv
// Sequencing state machine of the tare averager.
module ftsta_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  ftsta_pkg::sts_t sts,
	output ftsta_pkg::ctl_t ctl
);
	import ftsta_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_ACC, S_CHECK, S_DEN, S_LOAD, S_DIV, S_STORE, S_EMIT_AVG, S_EMIT
	} state_t;

	state_t            state_q;
	logic [AXIS_W-1:0] axis_q;
	logic              side_q;
	logic [2:0]        code_q;
	logic              scale_op_q;

	always_comb begin
		ctl          = '0;
		ctl.axis     = axis_q;
		ctl.side     = side_q;
		ctl.code     = code_q;
		ctl.ready    = (state_q == S_IDLE);
		case (state_q)
			S_DECODE: begin
				if (sts.cmd != CMD_SAMPLE && sts.mode == MODE_IDLE) begin
					ctl.clear = (sts.cmd == CMD_AIR) || (sts.cmd == CMD_GROUND);
					ctl.den   = (sts.cmd == CMD_APPLY);
				end
			end
			S_ACC: begin
				ctl.acc  = 1'b1;
				ctl.side = sts.foot;
				ctl.bump = sts.foot && (axis_q == AXIS_W'(AXES - 1));
			end
			S_LOAD: begin
				ctl.div_avg   = !scale_op_q;
				ctl.div_scale = scale_op_q;
			end
			S_STORE: begin
				ctl.store_avg   = !scale_op_q;
				ctl.store_scale = scale_op_q;
			end
			S_EMIT_AVG: begin
				ctl.emit     = sts.out_free;
				ctl.with_avg = 1'b1;
				ctl.last     = side_q;
				ctl.finish   = sts.out_free && side_q;
				ctl.code     = (sts.mode == MODE_AIR) ? ST_AIR_DONE : ST_GROUND_DONE;
			end
			S_EMIT: begin
				ctl.emit = sts.out_free;
				ctl.side = 1'b0;
				ctl.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			axis_q     <= '0;
			side_q     <= 1'b0;
			code_q     <= ST_STARTED;
			scale_op_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) state_q <= S_DECODE;
				end
				S_DECODE: begin
					axis_q     <= '0;
					side_q     <= 1'b0;
					scale_op_q <= 1'b0;
					if (sts.cmd == CMD_SAMPLE) begin
						state_q <= (sts.mode == MODE_IDLE) ? S_IDLE : S_ACC;
					end else if (sts.mode != MODE_IDLE) begin
						code_q  <= ST_BUSY;
						state_q <= S_EMIT;
					end else if (sts.cmd != CMD_APPLY) begin
						code_q  <= ST_STARTED;
						state_q <= S_EMIT;
					end else if (!sts.both_valid) begin
						code_q  <= ST_NO_DATA;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DEN;
					end
				end
				S_ACC: begin
					if (axis_q == AXIS_W'(AXES - 1)) begin
						axis_q  <= '0;
						state_q <= S_CHECK;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				S_CHECK: begin
					state_q <= sts.win_hit ? S_LOAD : S_IDLE;
				end
				S_DEN: begin
					if (sts.den_zero) begin
						code_q  <= ST_ZERO_DIV;
						state_q <= S_EMIT;
					end else begin
						scale_op_q <= 1'b1;
						state_q    <= S_LOAD;
					end
				end
				S_LOAD:  state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_done) state_q <= S_STORE;
				end
				S_STORE: begin
					if (scale_op_q) begin
						code_q  <= ST_APPLIED;
						state_q <= S_EMIT;
					end else if (axis_q == AXIS_W'(AXES - 1)) begin
						state_q <= S_EMIT_AVG;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_EMIT_AVG: begin
					if (sts.out_free) begin
						if (side_q) begin
							state_q <= S_IDLE;
						end else begin
							side_q  <= 1'b1;
							axis_q  <= '0;
							state_q <= S_LOAD;
						end
					end
				end
				S_EMIT: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sv/ftsta_dp.sv
// Datapath of the tare averager: sums, flags, shared divider and result register.
module ftsta_dp #(
	parameter int COUNT_WIDTH = ftsta_pkg::COUNT_WIDTH_DEF,
	parameter int VALUE_WIDTH = ftsta_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_fire,
	input  logic [1:0]                           in_cmd,
	input  logic                                 in_foot,
	input  logic [ftsta_pkg::AXES*VALUE_WIDTH-1:0] in_vals,
	input  logic                                 cfg_fire,
	input  logic                                 cfg_idx,
	input  logic [ftsta_pkg::WEIGHT_WIDTH-1:0]   cfg_val,
	input  ftsta_pkg::ctl_t                      ctl,
	output ftsta_pkg::sts_t                      sts,
	input  logic                                 out_take,
	output logic                                 out_valid,
	output logic [2:0]                           out_status,
	output logic                                 out_side,
	output logic [(ftsta_pkg::AXES+1)*VALUE_WIDTH-1:0] out_vals,
	output logic                                 out_last
);
	import ftsta_pkg::*;

	localparam int SW   = COUNT_WIDTH + VALUE_WIDTH;
	localparam int DENW = SW + 2;
	localparam int NUMB = WEIGHT_WIDTH + FRAC_BITS;
	localparam int NB   = (DENW > NUMB) ? DENW : NUMB;
	localparam int NW   = NB + 1;
	localparam int DW   = DENW;
	localparam int CW_D = $clog2(NW + 1);
	localparam logic [NW-1:0] POS_MAX = (NW'(1) << (VALUE_WIDTH - 1)) - NW'(1);
	localparam logic [NW-1:0] NEG_MAG = NW'(1) << (VALUE_WIDTH - 1);

	// item register
	logic [1:0]             cmd_q;
	logic                   foot_q;
	logic [VALUE_WIDTH-1:0] val_q [AXES];

	// configuration
	logic [COUNT_WIDTH-1:0]  window_q;
	logic [WEIGHT_WIDTH-1:0] weight_q;

	// architectural state
	logic [1:0]             mode_q;
	logic [COUNT_WIDTH-1:0] pair_q;
	logic                   air_valid_q, ground_valid_q;
	logic [SW-1:0]          sums_q [2][2*AXES];
	logic [VALUE_WIDTH-1:0] scale_q;
	logic [VALUE_WIDTH-1:0] avg_q [AXES];
	logic signed [DENW-1:0] den_q;

	// divider
	logic            div_busy_q;
	logic [CW_D-1:0] div_cnt_q;
	logic [NW-1:0]   div_num_q;
	logic [DW-1:0]   div_rem_q;
	logic [DW-1:0]   div_den_q;
	logic            div_neg_q;

	// result register
	logic                   ov_q;
	logic [2:0]             ost_q;
	logic                   oside_q;
	logic [VALUE_WIDTH-1:0] oavg_q [AXES];
	logic [VALUE_WIDTH-1:0] oscale_q;
	logic                   olast_q;

	logic                   set_sel;
	logic [IDX_W-1:0]       idx;
	logic [SW-1:0]          rd_sum;
	logic [COUNT_WIDTH-1:0] win;
	logic signed [DENW-1:0] den_new;
	logic [NW-1:0]          ld_mag, ld_add;
	logic [DW-1:0]          ld_den;
	logic                   ld_neg;
	logic [DW:0]            rem_sh;
	logic                   qbit;
	logic [VALUE_WIDTH-1:0] res;

	assign set_sel = (mode_q == MODE_GROUND);
	assign idx     = ctl.side ? IDX_W'(ctl.axis) + IDX_W'(AXES) : IDX_W'(ctl.axis);
	assign rd_sum  = sums_q[set_sel][idx];
	assign win     = (window_q == '0) ? COUNT_WIDTH'(1) : window_q;

	assign den_new = DENW'(signed'(sums_q[1][2])) + DENW'(signed'(sums_q[1][AXES + 2]))
	               - DENW'(signed'(sums_q[0][2])) - DENW'(signed'(sums_q[0][AXES + 2]));

	always_comb begin
		if (ctl.div_scale) begin
			ld_neg = den_q[DENW-1];
			ld_mag = NW'({weight_q, {FRAC_BITS{1'b0}}});
			ld_den = ld_neg ? DW'(-den_q) : DW'(den_q);
		end else begin
			ld_neg = rd_sum[SW-1];
			ld_mag = ld_neg ? NW'(-signed'(rd_sum)) : NW'(rd_sum);
			ld_den = DW'(win);
		end
		ld_add = ld_mag + NW'(ld_den >> 1);
	end

	assign rem_sh = {div_rem_q, div_num_q[NW-1]};
	assign qbit   = (rem_sh >= {1'b0, div_den_q});

	// round-half-away quotient, saturated to the value width
	always_comb begin
		if (!div_neg_q) begin
			res = (div_num_q > POS_MAX) ? VALUE_WIDTH'(POS_MAX) : div_num_q[VALUE_WIDTH-1:0];
		end else begin
			res = (div_num_q > NEG_MAG) ? VALUE_WIDTH'(NEG_MAG)
			                            : VALUE_WIDTH'(-div_num_q[VALUE_WIDTH-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q  <= in_cmd;
			foot_q <= in_foot;
			for (int i = 0; i < AXES; i++) begin
				val_q[i] <= in_vals[i*VALUE_WIDTH +: VALUE_WIDTH];
			end
		end
		if (ctl.clear) begin
			for (int i = 0; i < 2*AXES; i++) begin
				sums_q[cmd_q == CMD_GROUND][i] <= '0;
			end
		end
		if (ctl.acc) begin
			sums_q[set_sel][idx] <= rd_sum + SW'(signed'(val_q[ctl.axis]));
		end
		if (ctl.store_avg) begin
			sums_q[set_sel][idx] <= SW'(signed'(res));
			avg_q[ctl.axis]      <= res;
		end
		if (ctl.den) den_q <= den_new;
		if (ctl.div_avg || ctl.div_scale) begin
			div_num_q <= ld_add;
			div_den_q <= ld_den;
			div_rem_q <= '0;
			div_neg_q <= ld_neg;
		end else if (div_busy_q) begin
			div_num_q <= {div_num_q[NW-2:0], qbit};
			div_rem_q <= qbit ? DW'(rem_sh - {1'b0, div_den_q}) : rem_sh[DW-1:0];
		end
		if (ctl.emit) begin
			ost_q    <= ctl.code;
			oside_q  <= ctl.side;
			olast_q  <= ctl.last;
			oscale_q <= scale_q;
			for (int i = 0; i < AXES; i++) begin
				oavg_q[i] <= ctl.with_avg ? avg_q[i] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q       <= COUNT_WIDTH'(WINDOW_RESET);
			weight_q       <= '0;
			mode_q         <= MODE_IDLE;
			pair_q         <= '0;
			air_valid_q    <= 1'b0;
			ground_valid_q <= 1'b0;
			scale_q        <= VALUE_WIDTH'(SCALE_ONE);
			div_busy_q     <= 1'b0;
			div_cnt_q      <= '0;
			ov_q           <= 1'b0;
		end else begin
			if (cfg_fire) begin
				if (cfg_idx == CFG_WINDOW) window_q <= cfg_val[COUNT_WIDTH-1:0];
				else                       weight_q <= cfg_val;
			end
			if (ctl.clear) begin
				pair_q <= '0;
				mode_q <= cmd_q;
				if (cmd_q == CMD_AIR) air_valid_q    <= 1'b0;
				else                  ground_valid_q <= 1'b0;
			end
			if (ctl.bump) pair_q <= pair_q + 1'b1;
			if (ctl.finish) begin
				mode_q <= MODE_IDLE;
				if (mode_q == MODE_AIR) air_valid_q    <= 1'b1;
				else                    ground_valid_q <= 1'b1;
			end
			if (ctl.store_scale) scale_q <= res;
			if (ctl.div_avg || ctl.div_scale) begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= '0;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == CW_D'(NW - 1)) div_busy_q <= 1'b0;
			end
			if (ctl.emit)      ov_q <= 1'b1;
			else if (out_take) ov_q <= 1'b0;
		end
	end

	assign sts.cmd        = cmd_q;
	assign sts.foot       = foot_q;
	assign sts.mode       = mode_q;
	assign sts.both_valid = air_valid_q && ground_valid_q;
	assign sts.win_hit    = (pair_q >= win);
	assign sts.den_zero   = (den_q == '0);
	assign sts.div_done   = !div_busy_q;
	assign sts.out_free   = !ov_q || out_take;

	assign out_valid  = ov_q;
	assign out_status = ost_q;
	assign out_side   = oside_q;
	assign out_last   = olast_q;
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			out_vals[i*VALUE_WIDTH +: VALUE_WIDTH] = oavg_q[i];
		end
		out_vals[AXES*VALUE_WIDTH +: VALUE_WIDTH] = oscale_q;
	end

endmodule

// File: sv/ftsta_check.sv
// Port-level checks of the tare averager, bound to the top level.
module ftsta_check #(
	parameter int COUNT_WIDTH = ftsta_pkg::COUNT_WIDTH_DEF,
	parameter int VALUE_WIDTH = ftsta_pkg::VALUE_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [3:0] m_tuser,
	input logic m_tlast
);
	import ftsta_pkg::*;

	logic avg_kind;
	assign avg_kind = (m_tuser[2:0] == ST_AIR_DONE) || (m_tuser[2:0] == ST_GROUND_DONE);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// single-result answers always close their item
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !avg_kind |-> m_tlast && !m_tuser[3])
		else $error("single result without tlast or with side set");

	// averages come for side 0, then side 1; only the side-1 one closes the item
	a_side_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && avg_kind |-> (m_tlast == m_tuser[3]))
		else $error("average side and tlast disagree");

	// no new item is taken in the cycle after one was taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item taken while previous one in work");

endmodule

bind ft_sensor_tare_averager_top ftsta_check #(
	.COUNT_WIDTH (COUNT_WIDTH),
	.VALUE_WIDTH (VALUE_WIDTH)
) u_ftsta_check (.*);
